// ===== rtl/core/tsfm_pkg.sv =====
// Shared constants, codes and types of the touch sample filter and mapper.
`timescale 1ns / 1ps
package tsfm_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int FRAC_BITS  = 16;
  localparam int FILT_W     = SAMPLE_W + FRAC_BITS;
  localparam int W_BITS     = 16;
  localparam int W_OLD      = 64225;
  localparam int W_NEW      = 1311;
  localparam int W_NEW_W    = $clog2(W_NEW + 1);
  localparam int NEWT_W     = SAMPLE_W + W_NEW_W;
  localparam int COORD_W    = 16;
  localparam int SCALE_W    = 24;
  localparam int SCALE_BITS = 20;
  localparam int SCALE_RST  = 81920;
  localparam int MAX_SCANS  = 100;
  localparam int SCAN_W     = 7;
  localparam int TIME_W     = 32;
  localparam int MA_W       = COORD_W + FRAC_BITS + 1;
  localparam int MP_W       = MA_W + SCALE_W;
  localparam int MAP_SHIFT  = FRAC_BITS + SCALE_BITS;
  localparam int Q_W        = MP_W - MAP_SHIFT;
  localparam int SUM_W      = ((Q_W > COORD_W) ? Q_W : COORD_W) + 1;

  localparam int DATA_W     = 32;
  localparam int NUM_REGS   = 7;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int ADDR_W     = REG_IDX_W + 2;

  localparam logic [1:0] REQ_PEN_DOWN = 2'd0;
  localparam logic [1:0] REQ_SAMPLE   = 2'd1;
  localparam logic [1:0] REQ_PEN_UP   = 2'd2;

  localparam logic RESULT_PRESS   = 1'b0;
  localparam logic RESULT_RELEASE = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_LEFT_OFFSET   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_BOTTOM_OFFSET = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_X_ZERO_RAW    = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_Y_ZERO_RAW    = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_X_SCALE       = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_Y_SCALE       = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_CAPTURE_MODE  = REG_IDX_W'(6);

  typedef struct packed {
    logic [1:0]          req_type;
    logic [SAMPLE_W-1:0] x_sample;
    logic [SAMPLE_W-1:0] y_sample;
    logic [TIME_W-1:0]   time_ms;
  } in_item_t;

  typedef struct packed {
    logic                       result_kind;
    logic signed [COORD_W-1:0]  x_screen;
    logic signed [COORD_W-1:0]  y_screen;
    logic [SAMPLE_W-1:0]        x_smoothed;
    logic [SAMPLE_W-1:0]        y_smoothed;
    logic                       calib_capture;
    logic [TIME_W-1:0]          press_duration;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] left_offset;
    logic signed [COORD_W-1:0] bottom_offset;
    logic signed [COORD_W-1:0] x_zero_raw;
    logic signed [COORD_W-1:0] y_zero_raw;
    logic signed [SCALE_W-1:0] x_scale;
    logic signed [SCALE_W-1:0] y_scale;
    logic                      capture_mode;
  } cfg_t;

  typedef enum logic [1:0] {
    MUL_X_FILT,
    MUL_Y_FILT,
    MUL_X_MAP,
    MUL_Y_MAP
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     pen_down;
    logic     pen_up;
    mul_sel_e mul_sel;
    logic     take_scan;
    logic     upd_x;
    logic     upd_y;
    logic     map_x;
    logic     map_y;
    logic     emit_press;
    logic     emit_release;
  } ctrl_cmd_t;

  typedef struct packed {
    logic collecting;
    logic finish;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== rtl/core/tsfm_regs.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module tsfm_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsfm_pkg::ADDR_W-1:0] paddr,
  input  logic [tsfm_pkg::DATA_W-1:0] pwdata,
  output logic [tsfm_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output tsfm_pkg::cfg_t              cfg_o
);
  import tsfm_pkg::*;

  cfg_t                 cfg_q;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_offset   <= '0;
      cfg_q.bottom_offset <= '0;
      cfg_q.x_zero_raw    <= '0;
      cfg_q.y_zero_raw    <= '0;
      cfg_q.x_scale       <= SCALE_W'(SCALE_RST);
      cfg_q.y_scale       <= SCALE_W'(SCALE_RST);
      cfg_q.capture_mode  <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_LEFT_OFFSET:   cfg_q.left_offset   <= pwdata[COORD_W-1:0];
        REG_BOTTOM_OFFSET: cfg_q.bottom_offset <= pwdata[COORD_W-1:0];
        REG_X_ZERO_RAW:    cfg_q.x_zero_raw    <= pwdata[COORD_W-1:0];
        REG_Y_ZERO_RAW:    cfg_q.y_zero_raw    <= pwdata[COORD_W-1:0];
        REG_X_SCALE:       cfg_q.x_scale       <= pwdata[SCALE_W-1:0];
        REG_Y_SCALE:       cfg_q.y_scale       <= pwdata[SCALE_W-1:0];
        REG_CAPTURE_MODE:  cfg_q.capture_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LEFT_OFFSET:   prdata = DATA_W'(cfg_q.left_offset);
      REG_BOTTOM_OFFSET: prdata = DATA_W'(cfg_q.bottom_offset);
      REG_X_ZERO_RAW:    prdata = DATA_W'(cfg_q.x_zero_raw);
      REG_Y_ZERO_RAW:    prdata = DATA_W'(cfg_q.y_zero_raw);
      REG_X_SCALE:       prdata = DATA_W'(cfg_q.x_scale);
      REG_Y_SCALE:       prdata = DATA_W'(cfg_q.y_scale);
      REG_CAPTURE_MODE:  prdata = DATA_W'(cfg_q.capture_mode);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/tsfm_ctrl.sv =====
// Sequencing state machine: accepts items and steps the shared datapath.
`timescale 1ns / 1ps
module tsfm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            in_req_type_i,
  input  tsfm_pkg::ctrl_sts_t   sts_i,
  output logic                  in_ready_o,
  output tsfm_pkg::ctrl_cmd_t   cmd_o
);
  import tsfm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILT_X,
    ST_FILT_Y,
    ST_UPD_Y,
    ST_MAP_X,
    ST_MAP_Y,
    ST_MAP_DONE,
    ST_EMIT_PRESS,
    ST_EMIT_REL
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_X_FILT;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load     = accept;
        cmd_o.pen_down = accept && (in_req_type_i == REQ_PEN_DOWN);
        cmd_o.pen_up   = accept && (in_req_type_i == REQ_PEN_UP);
        if (accept && (in_req_type_i == REQ_PEN_UP)) begin
          state_d = ST_EMIT_REL;
        end else if (accept && (in_req_type_i == REQ_SAMPLE) && sts_i.collecting) begin
          state_d = ST_FILT_X;
        end
      end
      ST_FILT_X: begin
        cmd_o.mul_sel   = MUL_X_FILT;
        cmd_o.take_scan = 1'b1;
        state_d         = ST_FILT_Y;
      end
      ST_FILT_Y: begin
        cmd_o.mul_sel = MUL_Y_FILT;
        cmd_o.upd_x   = 1'b1;
        state_d       = ST_UPD_Y;
      end
      ST_UPD_Y: begin
        cmd_o.upd_y = 1'b1;
        state_d     = sts_i.finish ? ST_MAP_X : ST_IDLE;
      end
      ST_MAP_X: begin
        cmd_o.mul_sel = MUL_X_MAP;
        state_d       = ST_MAP_Y;
      end
      ST_MAP_Y: begin
        cmd_o.mul_sel = MUL_Y_MAP;
        cmd_o.map_x   = 1'b1;
        state_d       = ST_MAP_DONE;
      end
      ST_MAP_DONE: begin
        cmd_o.map_y = 1'b1;
        state_d     = ST_EMIT_PRESS;
      end
      ST_EMIT_PRESS: begin
        cmd_o.emit_press = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_REL: begin
        cmd_o.emit_release = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/tsfm_dp.sv =====
// Datapath: filter state, shared multiplier, screen mapping and output register.
`timescale 1ns / 1ps
module tsfm_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tsfm_pkg::in_item_t     in_item_i,
  input  tsfm_pkg::cfg_t         cfg_i,
  input  tsfm_pkg::ctrl_cmd_t    cmd_i,
  output tsfm_pkg::ctrl_sts_t    sts_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output tsfm_pkg::out_item_t    out_item_o
);
  import tsfm_pkg::*;

  localparam int RND_W = FILT_W + W_BITS + 1;
  localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(2 ** (W_BITS - 1));
  localparam logic signed [FILT_W+1:0] ONE_FILT = (FILT_W + 2)'(2 ** FRAC_BITS);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2 ** (COORD_W - 1) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(2 ** (COORD_W - 1)));
  localparam logic signed [SCALE_W-1:0] W_OLD_S = SCALE_W'(W_OLD);

  logic [FILT_W-1:0]         x_filt_q, y_filt_q;
  logic [SCAN_W-1:0]         scans_q;
  logic                      collecting_q;
  logic [TIME_W-1:0]         start_q, time_q;
  logic [SAMPLE_W-1:0]       xs_q, ys_q;
  logic [NEWT_W-1:0]         x_new_q, y_new_q;
  logic                      settle_x_q;
  logic signed [MP_W-1:0]    prod_q;
  logic signed [COORD_W-1:0] x_scr_q, y_scr_q;
  logic                      out_valid_q;
  out_item_t                 out_q;

  logic signed [MA_W-1:0]    x_diff, y_diff, mul_a;
  logic signed [SCALE_W-1:0] mul_b;
  logic [RND_W-1:0]          rnd_sum;
  logic [FILT_W:0]           filt_next;
  logic [FILT_W-1:0]         filt_old;
  logic signed [FILT_W+1:0]  filt_delta;
  logic                      settle;
  logic                      sample_nz;
  logic signed [SUM_W-1:0]   map_sum;
  logic signed [COORD_W-1:0] map_sat;
  logic                      out_free;

  assign x_diff = $signed(MA_W'(x_filt_q)) - ($signed(MA_W'(cfg_i.x_zero_raw)) <<< FRAC_BITS);
  assign y_diff = $signed(MA_W'(y_filt_q)) - ($signed(MA_W'(cfg_i.y_zero_raw)) <<< FRAC_BITS);

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_X_FILT: begin
        mul_a = $signed(MA_W'(x_filt_q));
        mul_b = W_OLD_S;
      end
      MUL_Y_FILT: begin
        mul_a = $signed(MA_W'(y_filt_q));
        mul_b = W_OLD_S;
      end
      MUL_X_MAP: begin
        mul_a = x_diff;
        mul_b = cfg_i.x_scale;
      end
      MUL_Y_MAP: begin
        mul_a = y_diff;
        mul_b = cfg_i.y_scale;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rnd_sum    = {1'b0, prod_q[FILT_W+W_BITS-1:0]} + ROUND_HALF;
  assign filt_next  = rnd_sum[RND_W-1:W_BITS]
                    + (FILT_W + 1)'(cmd_i.upd_y ? y_new_q : x_new_q);
  assign filt_old   = cmd_i.upd_y ? y_filt_q : x_filt_q;
  assign filt_delta = $signed({1'b0, filt_next}) - $signed({2'b00, filt_old});
  assign settle     = filt_delta < ONE_FILT;
  assign sample_nz  = (xs_q != '0) && (ys_q != '0);

  assign map_sum = $signed(SUM_W'($signed(prod_q[MP_W-1:MAP_SHIFT])))
                 + $signed(SUM_W'(cmd_i.map_y ? cfg_i.bottom_offset : cfg_i.left_offset));

  always_comb begin
    if (map_sum > SAT_HI) begin
      map_sat = SAT_HI[COORD_W-1:0];
    end else if (map_sum < SAT_LO) begin
      map_sat = SAT_LO[COORD_W-1:0];
    end else begin
      map_sat = map_sum[COORD_W-1:0];
    end
  end

  assign out_free          = !out_valid_q || out_ready_i;
  assign sts_o.collecting  = collecting_q;
  assign sts_o.finish      = (sample_nz && settle_x_q && settle) || (scans_q == '0);
  assign sts_o.out_free    = out_free;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_filt_q     <= '0;
      y_filt_q     <= '0;
      scans_q      <= '0;
      collecting_q <= 1'b0;
      start_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.pen_down) begin
        x_filt_q     <= '0;
        y_filt_q     <= '0;
        scans_q      <= SCAN_W'(MAX_SCANS);
        collecting_q <= 1'b1;
        start_q      <= in_item_i.time_ms;
      end
      if (cmd_i.pen_up) begin
        collecting_q <= 1'b0;
      end
      if (cmd_i.take_scan && (scans_q != '0)) begin
        scans_q <= scans_q - SCAN_W'(1);
      end
      if (cmd_i.upd_x && sample_nz) begin
        x_filt_q <= filt_next[FILT_W-1:0];
      end
      if (cmd_i.upd_y) begin
        if (sample_nz) begin
          y_filt_q <= filt_next[FILT_W-1:0];
        end
        if (sts_o.finish) begin
          collecting_q <= 1'b0;
        end
      end
      if (cmd_i.emit_press || cmd_i.emit_release) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.load) begin
      xs_q    <= in_item_i.x_sample;
      ys_q    <= in_item_i.y_sample;
      time_q  <= in_item_i.time_ms;
      x_new_q <= NEWT_W'(in_item_i.x_sample * W_NEW_W'(W_NEW));
      y_new_q <= NEWT_W'(in_item_i.y_sample * W_NEW_W'(W_NEW));
    end
    if (cmd_i.upd_x) begin
      settle_x_q <= settle;
    end
    if (cmd_i.map_x) begin
      x_scr_q <= map_sat;
    end
    if (cmd_i.map_y) begin
      y_scr_q <= map_sat;
    end
    if (cmd_i.emit_press) begin
      out_q.result_kind    <= RESULT_PRESS;
      out_q.x_screen       <= x_scr_q;
      out_q.y_screen       <= y_scr_q;
      out_q.x_smoothed     <= x_filt_q[FILT_W-1:FRAC_BITS];
      out_q.y_smoothed     <= y_filt_q[FILT_W-1:FRAC_BITS];
      out_q.calib_capture  <= cfg_i.capture_mode;
      out_q.press_duration <= '0;
    end else if (cmd_i.emit_release) begin
      out_q.result_kind    <= RESULT_RELEASE;
      out_q.x_screen       <= '0;
      out_q.y_screen       <= '0;
      out_q.x_smoothed     <= '0;
      out_q.y_smoothed     <= '0;
      out_q.calib_capture  <= 1'b0;
      out_q.press_duration <= time_q - start_q;
    end
  end

endmodule

// ===== rtl/core/touch_sample_filter_and_map.sv =====
// Top level of the touch sample filter and screen mapper.
//
// Input channel (in_valid_i/in_ready_o, in_item_i) carries touch items:
// pen down, coordinate sample or pen up. Output channel (out_valid_o/
// out_ready_i, out_item_o) carries press and release reports.
// One item is in work at a time; in_ready_o is high while the sequencer idles.
// Pen down, and any item that is dropped, is done in idle; pen up passes a release
// state to its report. A sample steps through X filter, Y filter and Y update,
// and when it ends the burst through X map, Y map, map done and press: a single
// multiplier is shared by the two filter steps and the two screen mappings.
// Reports sit in an output register; the next item is taken while a report
// waits, and the block only holds when a second report meets a full register.
// Reset clears the filters, the burst and the start time and loads register
// defaults (scale 81920, all others 0). Configuration must be written through
// the APB-style port only while the block is idle; this is not enforced.
`timescale 1ns / 1ps
module touch_sample_filter_and_map (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tsfm_pkg::in_item_t          in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tsfm_pkg::out_item_t         out_item_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsfm_pkg::ADDR_W-1:0] paddr,
  input  logic [tsfm_pkg::DATA_W-1:0] pwdata,
  output logic [tsfm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import tsfm_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  tsfm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tsfm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_req_type_i (in_item_i.req_type),
    .sts_i         (sts),
    .in_ready_o    (in_ready_o),
    .cmd_o         (cmd)
  );

  tsfm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.result_kind == RESULT_RELEASE) |->
      (out_item_o.x_screen == '0) && (out_item_o.y_screen == '0) &&
      (out_item_o.calib_capture == 1'b0))
    else $error("release item carries press fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.result_kind == RESULT_PRESS) |->
      (out_item_o.press_duration == '0))
    else $error("press item carries a duration");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.req_type == REQ_SAMPLE) && !sts.collecting
      |=> in_ready_o && !out_valid_o || in_ready_o)
    else $error("ignored sample did not return to idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.req_type == REQ_PEN_DOWN)
      |=> sts.collecting && in_ready_o)
    else $error("pen down did not arm a burst");
`endif

endmodule
